@@ rtl/rdp_pkg.sv @@
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared widths and types for the reuse distance profiler.
// ----------------------------------------------------------------------------
package rdp_pkg;

   localparam int SYM_W             = 8;
   localparam int DIST_W            = 8;
   localparam int SUM_W             = 24;
   localparam int CNT_W             = 16;
   localparam int ALPHABET_SIZE_DEF = 256;

   // search token that walks down the stack, one cell per cycle
   typedef struct packed {
      logic             valid;
      logic [SYM_W-1:0] key;    // symbol being looked up
      logic [SYM_W-1:0] carry;  // symbol pushed one place deeper
   } tok_type;

   // per-cell outcome while the token sits at that cell
   typedef struct packed {
      logic done;  // token stops here
      logic hit;   // stopped on a matching entry
   } cell_stat_type;

endpackage

@@ rtl/reuse_distance_profiler_core.sv @@
// ----------------------------------------------------------------------------
// reuse_distance_profiler_core
// LRU stack reuse distance profiler with saturating totals.
// ----------------------------------------------------------------------------
// The recency stack is a chain of ALPHABET_SIZE cells, most recent on top. An
// accepted symbol enters the top cell as a search token and moves one cell per
// cycle, pushing each symbol it passes one place deeper, until it meets its
// own earlier entry (a reuse, distance = cells passed) or an empty cell (a
// first access). The block takes no new symbol while a token walks; the
// next one is accepted once the walk has ended and the result word can be
// handed on. A symbol outside the alphabet makes no walk and gives its word
// directly.
// tuser on req carries start_req, which clears the stack and totals before
// the word is processed. tuser on rsp carries reused.
// ----------------------------------------------------------------------------
module reuse_distance_profiler_core #(
   parameter int ALPHABET_SIZE = rdp_pkg::ALPHABET_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tuser,   // [0] start_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] distance, [31:8] total_distance,
                                    // [47:32] reuse_count
   output logic        rsp_tuser    // [0] reused
);
   import rdp_pkg::*;

   localparam int STEP_W = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
   localparam logic [SYM_W:0] ALPHA_LIM = (SYM_W+1)'(ALPHABET_SIZE);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type            state_ff;
   tok_type              chain [ALPHABET_SIZE+1];
   cell_stat_type        stat  [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] done_vec;
   logic [ALPHABET_SIZE-1:0] hit_vec;
   logic                 done_any;
   logic                 hit_any;
   logic [STEP_W-1:0]    step_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_reused_ff;
   logic [DIST_W-1:0]    rsp_dist_ff;
   logic                 accept;
   logic                 clear;
   logic                 in_alpha;
   logic [SYM_W-1:0]     sym;
   logic [DIST_W-1:0]    walk_dist;
   logic [SUM_W:0]       sum_wide;
   logic [SUM_W-1:0]     sum_in;
   logic [CNT_W-1:0]     cnt_in;
   tok_type              tok0_ff;

   assign sym      = req_tdata[SYM_W-1:0];
   assign in_alpha = {1'b0, sym} < ALPHA_LIM;
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept   = req_tvalid && req_tready;
   assign clear    = accept && req_tuser;

   assign chain[0] = tok0_ff;

   for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
      rdp_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .clear   (clear),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1]),
         .stat    (stat[i])
      );
      assign done_vec[i] = stat[i].done;
      assign hit_vec[i]  = stat[i].hit;
   end

   // token leaving the last cell cannot happen; treated as a stop anyway
   assign done_any  = (|done_vec) || chain[ALPHABET_SIZE].valid;
   assign hit_any   = |hit_vec;
   assign walk_dist = DIST_W'(step_ff);

   assign sum_wide = {1'b0, sum_ff} + {{(SUM_W+1-DIST_W){1'b0}}, walk_dist};
   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (hit_any) begin
         sum_in = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
         if (cnt_ff != {CNT_W{1'b1}}) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok0_ff.valid <= 1'b0;
      end else begin
         tok0_ff.valid <= accept && in_alpha;
      end
      tok0_ff.key   <= sym;
      tok0_ff.carry <= sym;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         step_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_tuser) begin
                     sum_ff <= '0;
                     cnt_ff <= '0;
                  end
                  step_ff <= '0;
                  if (in_alpha) begin
                     state_ff <= ST_WALK;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            ST_WALK: begin
               step_ff <= step_ff + 1'b1;
               if (done_any) begin
                  sum_ff       <= sum_in;
                  cnt_ff       <= cnt_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result fields hold while the word waits on rsp_tready
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_reused_ff <= 1'b0;
         rsp_dist_ff   <= '0;
      end else if ((state_ff == ST_WALK) && done_any) begin
         rsp_reused_ff <= hit_any;
         rsp_dist_ff   <= hit_any ? walk_dist : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_reused_ff;
   assign rsp_tdata  = {cnt_ff, sum_ff, rsp_dist_ff};

endmodule

@@ rtl/rdp_cell.sv @@
// ----------------------------------------------------------------------------
// rdp_cell
// One entry of the LRU stack: takes the carried symbol, hands its own symbol
// on to the next deeper cell unless it matches the key or is empty.
// ----------------------------------------------------------------------------
module rdp_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  rdp_pkg::tok_type      tok_in,
   output rdp_pkg::tok_type      tok_out,
   output rdp_pkg::cell_stat_type stat
);
   import rdp_pkg::*;

   logic             valid_ff;
   logic [SYM_W-1:0] sym_ff;
   tok_type          tok_ff;
   logic             match;

   assign match     = valid_ff && (sym_ff == tok_in.key);
   assign stat.done = tok_in.valid && (!valid_ff || match);
   assign stat.hit  = tok_in.valid && match;
   assign tok_out   = tok_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (tok_in.valid) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_in.valid) begin
         sym_ff <= tok_in.carry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid && valid_ff && !match;
      end
      tok_ff.key   <= tok_in.key;
      tok_ff.carry <= sym_ff;
   end

endmodule

@@ tb/sv/reuse_distance_profiler_core_tb.sv @@
// ----------------------------------------------------------------------------
// reuse_distance_profiler_core_tb
// Self-checking bench for the LRU stack reuse distance profiler. A short
// directed table comes first, then random traces. The traces use small and
// large working sets, start-of-trace clears and a full sweep of the alphabet.
// Each result word is compared field by field against the expected word typed
// into the table or an in-bench LRU depth model. Both stream sides idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module reuse_distance_profiler_core_tb;

   import rdp_pkg::*;

   localparam int    NUM_SYMBOLS  = ALPHABET_SIZE_DEF;
   localparam int    RANDOM_WORDS = 800;
   localparam int    STALL_LIMIT  = 5000;
   localparam int    HOLD_CYCLES  = 400;
   localparam int    DRAIN_CYCLES = 300;
   localparam [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};
   localparam [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};
   localparam [DIST_W-1:0] DEPTH_SAT = {DIST_W{1'b1}};

   typedef struct packed {
      logic              reused;
      logic [DIST_W-1:0] distance;
      logic [SUM_W-1:0]  total;
      logic [CNT_W-1:0]  count;
   } profile_word_type;

   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             start_trace;
      logic             known;      // expected word typed in below
      profile_word_type word;
   } directed_row_type;

   localparam int NUM_DIRECTED = 18;

   // sym, start, known, {reused, distance, total, count}
   directed_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      '{8'd0,   1'b0, 1'b1, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'd255, 1'b0, 1'b1, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'd0,   1'b0, 1'b1, '{1'b1, 8'd1, 24'd1, 16'd1}},
      '{8'd0,   1'b0, 1'b1, '{1'b1, 8'd0, 24'd1, 16'd2}},
      '{8'd128, 1'b0, 1'b0, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'd255, 1'b0, 1'b0, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'd1,   1'b1, 1'b1, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'd1,   1'b0, 1'b1, '{1'b1, 8'd0, 24'd0, 16'd1}},
      '{8'd2,   1'b0, 1'b0, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'd3,   1'b0, 1'b0, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'd4,   1'b0, 1'b0, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'd5,   1'b0, 1'b0, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'd1,   1'b0, 1'b0, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'd3,   1'b0, 1'b0, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'd254, 1'b1, 1'b1, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'd254, 1'b1, 1'b1, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'hAA,  1'b0, 1'b0, '{1'b0, 8'd0, 24'd0, 16'd0}},
      '{8'h55,  1'b0, 1'b0, '{1'b0, 8'd0, 24'd0, 16'd0}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] symbol
   logic        req_tuser = 1'b0; // [0] start_req
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [7:0] distance, [31:8] total_distance,
                                  // [47:32] reuse_count
   logic        rsp_tuser;        // [0] reused

   // LRU depth model state
   logic              sym_seen    [0:NUM_SYMBOLS-1];
   logic [DIST_W-1:0] stack_depth [0:NUM_SYMBOLS-1];
   logic [SUM_W-1:0]  distance_total = '0;
   logic [CNT_W-1:0]  repeat_total = '0;

   profile_word_type pending_words [$];
   int            words_outstanding = 0;
   int            words_received = 0;
   int            fail_count = 0;
   int            idle_cycles = 0;
   logic          no_idle = 1'b0;
   logic          hold_done = 1'b0;

   reuse_distance_profiler_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      for (int k = 0; k < NUM_SYMBOLS; k++) begin
         sym_seen[k]    = 1'b0;
         stack_depth[k] = '0;
      end
   end

   // One access against the LRU stack; returns the word the block should emit.
   function automatic profile_word_type lru_access(input logic [SYM_W-1:0] sym,
                                                   input logic start_trace);
      profile_word_type  r;
      logic [DIST_W-1:0] depth;
      logic [SUM_W:0]    sum_wide;
      r = '0;
      if (start_trace) begin
         for (int k = 0; k < NUM_SYMBOLS; k++) begin
            sym_seen[k]    = 1'b0;
            stack_depth[k] = '0;
         end
         distance_total = '0;
         repeat_total   = '0;
      end
      if (!sym_seen[sym]) begin
         // first access pushes everything down one place
         for (int k = 0; k < NUM_SYMBOLS; k++)
            if (sym_seen[k] && stack_depth[k] != DEPTH_SAT)
               stack_depth[k] = stack_depth[k] + 1'b1;
      end else begin
         depth = stack_depth[sym];
         // only symbols above the reused one move down
         for (int k = 0; k < NUM_SYMBOLS; k++)
            if (sym_seen[k] && k != sym && stack_depth[k] < depth)
               stack_depth[k] = stack_depth[k] + 1'b1;
         r.reused   = 1'b1;
         r.distance = depth;
         sum_wide   = {1'b0, distance_total} + {{(SUM_W+1-DIST_W){1'b0}}, depth};
         distance_total = (sum_wide > {1'b0, SUM_SAT}) ? SUM_SAT : sum_wide[SUM_W-1:0];
         if (repeat_total != CNT_SAT)
            repeat_total = repeat_total + 1'b1;
      end
      sym_seen[sym]    = 1'b1;
      stack_depth[sym] = '0;
      r.total = distance_total;
      r.count = repeat_total;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("MISMATCH word %0d %s: got %0d, want %0d", words_received, field, got,
               want);
      fail_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input logic [SYM_W-1:0] sym, input logic start_trace,
                            input logic known, input profile_word_type known_word);
      profile_word_type predicted;
      while (!no_idle && $urandom_range(0, 99) < 31) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = sym;
      req_tuser  = start_trace;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = lru_access(sym, start_trace);
      pending_words.push_back(known ? known_word : predicted);
      words_outstanding++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // result side: random backpressure plus one long hold-off
   initial begin
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (!hold_done && words_received >= 120) begin
            hold_done  = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready = no_idle || ($urandom_range(0, 99) >= 31);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      profile_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = pending_words.pop_front();
            words_outstanding--;
            if (rsp_tuser != want.reused)
               report_mismatch("reused", rsp_tuser, want.reused);
            if (rsp_tdata[7:0] != want.distance)
               report_mismatch("distance", rsp_tdata[7:0], want.distance);
            if (rsp_tdata[31:8] != want.total)
               report_mismatch("total_distance", rsp_tdata[31:8], want.total);
            if (rsp_tdata[47:32] != want.count)
               report_mismatch("reuse_count", rsp_tdata[47:32], want.count);
         end
         words_received++;
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [SYM_W-1:0] sweep_order [0:NUM_SYMBOLS-1];
      logic [SYM_W-1:0] sym;
      logic [SYM_W-1:0] swap;
      logic [SYM_W-1:0] base;
      int               random_sent;
      int               seg_len;
      int               ws_size;
      int               j;
      logic             new_trace;
      logic             pause_done;
      logic             sweep_done;
      random_sent = 0;
      pause_done  = 1'b0;
      sweep_done  = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_word(directed_rows[i].sym, directed_rows[i].start_trace,
                   directed_rows[i].known, directed_rows[i].word);

      while (random_sent < RANDOM_WORDS) begin
         if (!sweep_done && random_sent >= 500) begin
            // touch the whole alphabet in shuffled order, then reach back deep
            sweep_done = 1'b1;
            for (int k = 0; k < NUM_SYMBOLS; k++)
               sweep_order[k] = SYM_W'(k);
            for (int k = NUM_SYMBOLS - 1; k > 0; k--) begin
               j              = int'($urandom_range(0, k));
               swap           = sweep_order[k];
               sweep_order[k] = sweep_order[j];
               sweep_order[j] = swap;
            end
            for (int k = 0; k < NUM_SYMBOLS; k++)
               send_word(sweep_order[k], k == 0, 1'b0, '0);
            send_word(sweep_order[0], 1'b0, 1'b0, '0);
            for (int k = 0; k < 40; k++)
               send_word(sweep_order[$urandom_range(0, 127)], 1'b0, 1'b0, '0);
            random_sent += NUM_SYMBOLS + 41;
         end else begin
            seg_len   = int'($urandom_range(8, 60));
            ws_size   = 1 << $urandom_range(1, 8);
            base      = SYM_W'($urandom);
            new_trace = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < seg_len; i++) begin
               if ($urandom_range(0, 9) == 0)
                  sym = SYM_W'($urandom);
               else
                  sym = base + SYM_W'($urandom_range(0, ws_size - 1));
               send_word(sym, (new_trace && i == 0) || ($urandom_range(0, 199) == 0),
                         1'b0, '0);
               random_sent++;
               no_idle = (random_sent >= 320 && random_sent < 440);
               if (!pause_done && random_sent >= 250) begin
                  // let the pipeline drain completely before going on
                  pause_done = 1'b1;
                  wait (words_outstanding == 0);
                  @(negedge clock);
               end
            end
         end
      end
      no_idle = 1'b0;

      wait (words_outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_words.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
